FILE: src/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg - shared types and constants for the LZSS byte decompressor
// Widths, token constants and the command passed from front end to back end.
// ----------------------------------------------------------------------------
package lbd_pkg;

    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 24;              // output byte counter / out_size
    localparam int WIN_AW     = 12;              // 4096-byte history window
    localparam int DIST_W     = 12;
    localparam int DIST_SHIFT = 4;
    localparam int LEN_W      = 5;               // holds 1..18: match lengths 3..18, capped or literal down to 1
    localparam int LEN_BIAS   = 3;
    localparam int FLAG_W     = 9;               // eight flag bits plus marker
    localparam logic [FLAG_W-1:0] FLAG_MARK  = 9'h100;
    localparam logic [FLAG_W-1:0] FLAG_RESET = 9'd2;
    localparam int QPTR_W     = 1;
    localparam int QUEUE_DEPTH = 1 << QPTR_W;

    // One decoded token: a literal byte or a back-reference copy.
    typedef struct packed {
        logic                is_lit;
        logic [BYTE_W-1:0]   lit;
        logic [DIST_W-1:0]   distance;
        logic [LEN_W-1:0]    len;     // bytes to produce, never zero
        logic [COUNT_W-1:0]  start;   // output count before the first byte
    } t_cmd;

endpackage

FILE: src/lbd_in_if.sv
// ----------------------------------------------------------------------------
// lbd_in_if - compressed byte channel
// valid/ready handshake carrying one stream byte and the frame start mark.
// ----------------------------------------------------------------------------
interface lbd_in_if;
    logic                      valid;
    logic                      ready;
    logic [lbd_pkg::BYTE_W-1:0] in_byte;
    logic                      frame_start;

    modport source (output valid, output in_byte, output frame_start, input ready);
    modport sink   (input valid, input in_byte, input frame_start, output ready);
endinterface

FILE: src/lbd_out_if.sv
// ----------------------------------------------------------------------------
// lbd_out_if - decompressed byte channel
// valid/ready handshake carrying one output byte and its status bits.
// ----------------------------------------------------------------------------
interface lbd_out_if;
    logic                      valid;
    logic                      ready;
    logic [lbd_pkg::BYTE_W-1:0] out_byte;
    logic                      run_last;
    logic                      image_end;
    logic                      bad_distance;

    modport source (output valid, output out_byte, output run_last, output image_end,
                    output bad_distance, input ready);
    modport sink   (input valid, input out_byte, input run_last, input image_end,
                    input bad_distance, output ready);
endinterface

FILE: src/lbd_cfg_if.sv
// ----------------------------------------------------------------------------
// lbd_cfg_if - configuration write channel
// valid/ready handshake carrying the out_size register value.
// ----------------------------------------------------------------------------
interface lbd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lbd_pkg::COUNT_W-1:0] out_size;

    modport source (output valid, output out_size, input ready);
    modport sink   (input valid, input out_size, output ready);
endinterface

FILE: src/lbd_front.sv
// ----------------------------------------------------------------------------
// lbd_front - token parser
// Tracks flag bits and token phase, turns stream bytes into literal and copy commands.
// ----------------------------------------------------------------------------
module lbd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lbd_in_if.sink                      i_in,
    input  logic [lbd_pkg::COUNT_W-1:0] i_out_size,
    input  logic                        i_q_full,
    output logic                        o_push,
    output lbd_pkg::t_cmd               o_cmd
);
    import lbd_pkg::*;

    typedef enum logic [1:0] {
        PH_TOKEN    = 2'd0,   // next byte starts a token (or reloads flags)
        PH_BODY     = 2'd1,   // flags just loaded, byte is a token body
        PH_MATCH_HI = 2'd2    // second byte of a match
    } t_phase;

    t_phase              r_phase, n_phase, ph_cur;
    logic [FLAG_W-1:0]   r_flag, n_flag, flag_cur, shifted, flag_use;
    logic [BYTE_W-1:0]   r_low, n_low, low_cur;
    logic [COUNT_W-1:0]  r_count, n_count, cnt_cur, rem;
    logic [LEN_W-1:0]    len_full, cap;
    logic                accept;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    always_comb begin
        ph_cur   = i_in.frame_start ? PH_TOKEN   : r_phase;
        flag_cur = i_in.frame_start ? FLAG_RESET : r_flag;
        low_cur  = i_in.frame_start ? '0         : r_low;
        cnt_cur  = i_in.frame_start ? '0         : r_count;

        shifted  = flag_cur >> 1;
        flag_use = (ph_cur == PH_TOKEN) ? shifted : flag_cur;
        len_full = {1'b0, low_cur[DIST_SHIFT-1:0]} + LEN_W'(LEN_BIAS);
        rem      = i_out_size - cnt_cur;
        cap      = (COUNT_W'(len_full) > rem) ? rem[LEN_W-1:0] : len_full;

        n_phase = ph_cur;
        n_flag  = flag_cur;
        n_low   = low_cur;
        n_count = cnt_cur;
        o_push  = 1'b0;
        o_cmd   = '0;
        o_cmd.start = cnt_cur;

        if (cnt_cur < i_out_size) begin
            unique case (ph_cur)
                PH_MATCH_HI: begin
                    o_push         = accept;
                    o_cmd.distance = {i_in.in_byte, low_cur[BYTE_W-1:DIST_SHIFT]};
                    o_cmd.len      = cap;
                    n_count        = cnt_cur + COUNT_W'(cap);
                    n_phase        = PH_TOKEN;
                end
                PH_TOKEN, PH_BODY: begin
                    priority if (ph_cur == PH_TOKEN && shifted <= FLAG_W'(1)) begin
                        n_flag  = FLAG_MARK | FLAG_W'(i_in.in_byte);
                        n_phase = PH_BODY;
                    end else if (flag_use[0]) begin
                        n_flag       = flag_use;
                        o_push       = accept;
                        o_cmd.is_lit = 1'b1;
                        o_cmd.lit    = i_in.in_byte;
                        o_cmd.len    = LEN_W'(1);
                        n_count      = cnt_cur + COUNT_W'(1);
                        n_phase      = PH_TOKEN;
                    end else begin
                        n_flag  = flag_use;
                        n_low   = i_in.in_byte;
                        n_phase = PH_MATCH_HI;
                    end
                end
                default: n_phase = PH_TOKEN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOKEN;
            r_flag  <= FLAG_RESET;
            r_low   <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_flag  <= n_flag;
            r_low   <= n_low;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_push_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_cmd.len != '0 && o_cmd.len <= LEN_W'(18)))
        else $error("front pushed a command with bad length");
`endif

endmodule

FILE: src/lbd_queue.sv
// ----------------------------------------------------------------------------
// lbd_queue - command queue
// Small FIFO decoupling the token parser from the copy engine.
// ----------------------------------------------------------------------------
module lbd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lbd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output lbd_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import lbd_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_fill;

    assign o_full  = (r_fill == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + QPTR_W'(1);
            if (i_pop)  r_rd <= r_rd + QPTR_W'(1);
            r_fill <= r_fill + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");
`endif

endmodule

FILE: src/lbd_back.sv
// ----------------------------------------------------------------------------
// lbd_back - copy engine
// Executes commands through the 4096-byte history, one output byte at a time.
// ----------------------------------------------------------------------------
module lbd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [lbd_pkg::COUNT_W-1:0] i_out_size,
    input  logic                        i_empty,
    input  lbd_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    lbd_out_if.source                   o_out
);
    import lbd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic                r_lit;
    logic [BYTE_W-1:0]   r_byte;
    logic [DIST_W-1:0]   r_dist;
    logic [LEN_W-1:0]    r_left;
    logic [COUNT_W-1:0]  r_count, count_inc;
    logic [BYTE_W-1:0]   r_hist [1 << WIN_AW];
    logic [BYTE_W-1:0]   r_rd_data, value;
    logic [WIN_AW-1:0]   rd_addr;
    logic                bad, out_free, fire;
    logic                r_ov, r_rl, r_ie, r_bd;
    logic [BYTE_W-1:0]   r_ob;

    assign out_free  = !r_ov || o_out.ready;
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign fire      = (r_state == S_EMIT) && out_free;
    assign rd_addr   = r_count[WIN_AW-1:0] - r_dist;
    assign bad       = !r_lit && (COUNT_W'(r_dist) > r_count);
    assign count_inc = r_count + COUNT_W'(1);

    always_comb begin
        priority if (r_lit)                   value = r_byte;
        else if (bad || r_dist == '0)         value = '0;
        else                                  value = r_rd_data;
    end

    // history: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_hist[r_count[WIN_AW-1:0]] <= value;
        end
        r_rd_data <= r_hist[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (fire) r_ov <= 1'b1;
            else if (o_out.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_lit   <= i_cmd.is_lit;
                        r_byte  <= i_cmd.lit;
                        r_dist  <= i_cmd.distance;
                        r_left  <= i_cmd.len;
                        r_count <= i_cmd.start;
                        r_state <= i_cmd.is_lit ? S_EMIT : S_READ;
                    end
                end
                S_READ: r_state <= S_EMIT;
                S_EMIT: begin
                    if (out_free) begin
                        r_ob    <= value;
                        r_rl    <= (r_left == LEN_W'(1));
                        r_ie    <= (count_inc == i_out_size);
                        r_bd    <= bad;
                        r_count <= count_inc;
                        r_left  <= r_left - LEN_W'(1);
                        r_state <= (r_left == LEN_W'(1)) ? S_IDLE : S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.out_byte     = r_ob;
    assign o_out.run_last     = r_rl;
    assign o_out.image_end    = r_ie;
    assign o_out.bad_distance = r_bd;

`ifndef SYNTHESIS
    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_left != '0))
        else $error("copy engine active with no bytes left");
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && count_inc == i_out_size) |-> (r_left == LEN_W'(1)))
        else $error("frame end reached before end of token");
`endif

endmodule

FILE: src/lzss_byte_decompressor_unit.sv
// Path: a literal passes the command queue, engine command registers and output register;
//   a match's first byte also waits for the registered history read in S_READ.
// Flow: the parser takes a stream byte whenever the queue is not full; the copy engine
//   pops a literal and emits it, and for each match byte reads history, then emits and writes.
// Reset (synchronous, active low) clears parser state, queue, engine and out_size;
//   the history memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// lzss_byte_decompressor_unit - LZSS byte-stream decompressor
// 12-bit distance, 4-bit length LZSS with a 4096-byte history window.
// ----------------------------------------------------------------------------
module lzss_byte_decompressor_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lbd_in_if.sink    i_in,
    lbd_out_if.source o_out,
    lbd_cfg_if.sink   i_cfg
);
    import lbd_pkg::*;

    // out_size register; the user must issue writes only while the unit is idle (not enforced here)
    logic [COUNT_W-1:0] r_out_size;

    // parser -> queue -> copy engine
    logic q_push, q_full, q_pop, q_empty;
    t_cmd q_in_cmd, q_out_cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_size <= '0;
        end else if (i_cfg.valid) begin
            r_out_size <= i_cfg.out_size;
        end
    end

    // Front end: flag tracking, token classification, projected output count
    // (so length capping and end-of-frame skipping need nothing from the back).
    lbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_out_size (r_out_size),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (q_in_cmd)
    );

    // Two-entry command queue lets the parser run ahead of a long copy.
    lbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out_cmd),
        .o_empty (q_empty)
    );

    // Back end: byte-by-byte copy through history, output register.
    lbd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_out_size (r_out_size),
        .i_empty    (q_empty),
        .i_cmd      (q_out_cmd),
        .o_pop      (q_pop),
        .o_out      (o_out)
    );

endmodule
